// ----- rtl/segment_partition_dp_hull_defines.svh -----
// Assertion macros for the partition block.
`ifndef SEGMENT_PARTITION_DP_HULL_DEFINES_SVH
`define SEGMENT_PARTITION_DP_HULL_DEFINES_SVH
`ifndef SYNTH
`define SPH_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPH_ASSERT_RST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPH_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPH_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/sph_pkg.sv -----
`default_nettype none
package sph_pkg;
	localparam int PREFIX_W = 18;
	localparam int SLOPE_W  = 30;
	localparam int SCORE_W  = 64;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONST = 2'd2;

	typedef struct packed {
		logic [7:0] item_value;
		logic       seq_last;
	} in_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] best_score;
		logic               score_last;
	} out_item_t;

	// multiplier unit operation
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;
endpackage
`default_nettype wire

// ----- rtl/sph_if.sv -----
`default_nettype none
interface sph_in_if;
	logic valid;
	logic ready;
	logic [7:0] item_value;
	logic seq_last;
	modport source (output valid, item_value, seq_last, input ready);
	modport sink (input valid, item_value, seq_last, output ready);
endinterface

interface sph_out_if;
	logic valid;
	logic ready;
	logic signed [63:0] best_score;
	logic score_last;
	modport source (output valid, best_score, score_last, input ready);
	modport sink (input valid, best_score, score_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/sph_mul.sv -----
`default_nettype none
`include "segment_partition_dp_hull_defines.svh"
// Shared 64x64 multiplier, one 32x32 partial product per cycle.
// Gives the full 128-bit unsigned product; callers take what they need.
module sph_mul (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire sph_pkg::mul_req_t req,
	output logic [127:0] prod,
	output logic done
);
	import sph_pkg::*;
	logic [63:0] a_q, b_q;
	logic [127:0] acc_q;
	logic [1:0] step_q;
	logic busy_q;
	logic [63:0] pp;
	logic [31:0] pa, pb;

	assign pa = step_q[0] ? a_q[63:32] : a_q[31:0];
	assign pb = step_q[1] ? b_q[63:32] : b_q[31:0];
	assign pp = {32'd0, pa} * {32'd0, pb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + ({64'd0, pp} << {step_q[1], 5'd0} << {step_q[0], 5'd0});
		end
	end
	assign prod = acc_q;

	`SPH_ASSERT(a_done_pulse, clk, arst_n, done |=> !done, "done longer than one cycle")
	`SPH_ASSERT(a_no_restart, clk, arst_n, busy_q |-> !req.start, "restart while busy")
	`SPH_ASSERT_RST(a_rst_idle, clk, !arst_n |=> !done, "done during reset")
endmodule
`default_nettype wire

// ----- rtl/segment_partition_dp_hull.sv -----
// Channel | dir | payload                      | handshake
// in      | in  | item_value[8], seq_last      | valid/ready
// out     | out | best_score[64], score_last   | valid/ready
// cfg     | in  | cfg_index[2], cfg_data[32]   | cfg_we, no stall
//
// One item per pass of a small sequencer; every 64-bit product goes through
// one shared multiplier, and the sequencer waits for each product. An item
// runs accept, line build (2 products), push, pointer line (1 product),
// score (2 products), result. Before the push, each hull test adds 2 reads
// and 2 products and pops the top line when it is redundant; after the
// pointer line, each pointer check adds 1 read and 1 product.
// Reset clears control state, lin and const, sets quad to -1; hull memory
// is not cleared, entries are only read below the fill count. Input is
// ready only when idle; a result waits in its register until taken and the
// block stalls at the result step only if the previous one is still waiting.
`default_nettype none
`include "segment_partition_dp_hull_defines.svh"
module segment_partition_dp_hull #(
	parameter int MAX_LINES = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	sph_in_if.sink in_ch,
	sph_out_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [sph_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [sph_pkg::CFG_W-1:0] cfg_data
);
	import sph_pkg::*;
	localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int CW = AW + 1;

	localparam logic [4:0] ST_IDLE=5'd0, ST_A_GO=5'd1, ST_A_WT=5'd2, ST_B_GO=5'd3,
		ST_B_WT=5'd4, ST_PCHK=5'd5, ST_PRD1=5'd6, ST_PRD2=5'd7, ST_PM1_GO=5'd8,
		ST_PM1_WT=5'd9, ST_PM2_GO=5'd10, ST_PM2_WT=5'd11, ST_PUSH=5'd12,
		ST_QCLAMP=5'd13, ST_QV_LD=5'd14, ST_QV_GO=5'd15, ST_QV_WT=5'd16,
		ST_QLAST=5'd17, ST_QN_LD=5'd18, ST_QN_GO=5'd19, ST_QN_WT=5'd20,
		ST_S_GO=5'd21, ST_S_WT=5'd22, ST_S2_GO=5'd23, ST_S2_WT=5'd24, ST_OUT=5'd25;

	logic [4:0] state_q;
	logic signed [10:0] quad_q;
	logic signed [23:0] lin_q;
	logic signed [31:0] const_q;
	logic [PREFIX_W-1:0] psum_q, s_q;
	logic [63:0] prev_best_q;
	logic [CW-1:0] count_q, qp_q;
	logic last_q;
	// new line (m3, b3), shared temp, pointer value, score
	logic [63:0] m3_q, icpt_q, tmp_q, va_q, best_q;
	// hull memory
	logic [SLOPE_W-1:0] slope_mem [MAX_LINES];
	logic [63:0] icpt_mem [MAX_LINES];
	logic [AW-1:0] rd_addr;
	logic [SLOPE_W-1:0] rd_slope_q;
	logic [63:0] rd_icpt_q;
	logic [63:0] m1_q, b1_q, m2_q, b2_q;
	logic [127:0] lp_q;
	logic ln_q;
	logic wr_en;
	logic [AW-1:0] wr_addr;

	mul_req_t mreq;
	logic [127:0] mprod;
	logic mdone;
	sph_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .prod(mprod), .done(mdone));

	logic [63:0] quad64, lin64, const64, p64, s64;
	assign quad64 = {{53{quad_q[10]}}, quad_q};
	assign lin64 = {{40{lin_q[23]}}, lin_q};
	assign const64 = {{32{const_q[31]}}, const_q};
	assign p64 = {{(64-PREFIX_W){1'b0}}, psum_q};
	assign s64 = {{(64-PREFIX_W){1'b0}}, s_q};

	// slope = -2*quad*P, kept as a sign-extended 30-bit value
	logic [63:0] slope64;
	assign slope64 = 64'd0 - {mprod[62:0], 1'b0};

	// hull test operand magnitudes: first product (b3-b1)*(m1-m2),
	// second (b2-b1)*(m1-m3)
	logic [63:0] bd1, bd2, sdm1, sdm2;
	logic bn1, bn2, sn1, sn2;
	logic [63:0] sd1, sd2;
	assign bn1 = $signed(icpt_q) < $signed(b1_q);
	assign bd1 = bn1 ? b1_q - icpt_q : icpt_q - b1_q;
	assign bn2 = $signed(b2_q) < $signed(b1_q);
	assign bd2 = bn2 ? b1_q - b2_q : b2_q - b1_q;
	assign sd1 = m1_q - m2_q;
	assign sd2 = m1_q - m3_q;
	assign sn1 = sd1[63];
	assign sn2 = sd2[63];
	assign sdm1 = sn1 ? -sd1 : sd1;
	assign sdm2 = sn2 ? -sd2 : sd2;

	// middle line is redundant when left product <= right product (signed)
	logic rn;
	logic redundant;
	assign rn = (mprod != '0) && (bn2 != sn2);
	always_comb begin
		if (ln_q != rn) redundant = ln_q;
		else if (!ln_q) redundant = lp_q <= mprod;
		else redundant = lp_q >= mprod;
	end

	// pointer: clamp to top line, then advance while the next line is larger
	logic [CW-1:0] qp_c;
	logic [63:0] tn;
	logic adv;
	assign qp_c = (qp_q >= count_q) ? count_q - CW'(1) : qp_q;
	assign tn = mprod[63:0] + b2_q;
	assign adv = $signed(va_q) < $signed(tn);

	logic [63:0] rd_slope64;
	assign rd_slope64 = {{(64-SLOPE_W){rd_slope_q[SLOPE_W-1]}}, rd_slope_q};

	assign wr_en = (state_q == ST_PUSH) && (count_q < CW'(MAX_LINES));
	assign wr_addr = count_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slope_mem[wr_addr] <= m3_q[SLOPE_W-1:0];
			icpt_mem[wr_addr] <= icpt_q;
		end
		rd_slope_q <= slope_mem[rd_addr];
		rd_icpt_q <= icpt_mem[rd_addr];
	end

	always_comb begin
		rd_addr = qp_q[AW-1:0];
		case (state_q)
			ST_PCHK: rd_addr = AW'(count_q - CW'(2));
			ST_PRD1: rd_addr = AW'(count_q - CW'(1));
			ST_QCLAMP: rd_addr = qp_c[AW-1:0];
			ST_QLAST: rd_addr = AW'(qp_q + CW'(1));
			default: ;
		endcase
	end

	// multiplier launches, one per *_GO state
	always_comb begin
		mreq = '0;
		case (state_q)
			ST_A_GO: begin mreq.start = 1'b1; mreq.a = quad64; mreq.b = p64; end
			ST_B_GO: begin mreq.start = 1'b1; mreq.a = tmp_q; mreq.b = p64; end
			ST_PM1_GO: begin mreq.start = 1'b1; mreq.a = bd1; mreq.b = sdm1; end
			ST_PM2_GO: begin mreq.start = 1'b1; mreq.a = bd2; mreq.b = sdm2; end
			ST_QV_GO: begin mreq.start = 1'b1; mreq.a = m1_q; mreq.b = s64; end
			ST_QN_GO: begin mreq.start = 1'b1; mreq.a = m2_q; mreq.b = s64; end
			ST_S_GO: begin mreq.start = 1'b1; mreq.a = quad64; mreq.b = s64; end
			ST_S2_GO: begin mreq.start = 1'b1; mreq.a = tmp_q; mreq.b = s64; end
			default: ;
		endcase
	end

	logic in_acc;
	logic out_free;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign out_free = !out_ch.valid || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			quad_q <= -11'sd1;
			lin_q <= '0;
			const_q <= '0;
			psum_q <= '0;
			prev_best_q <= '0;
			count_q <= '0;
			qp_q <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_QUAD: quad_q <= cfg_data[10:0];
					REG_LIN: lin_q <= cfg_data[23:0];
					REG_CONST: const_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_OUT && out_free) out_ch.valid <= 1'b1;
			else if (out_ch.ready) out_ch.valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_A_GO;
				ST_A_GO: state_q <= ST_A_WT;
				ST_A_WT: if (mdone) state_q <= ST_B_GO;
				ST_B_GO: state_q <= ST_B_WT;
				ST_B_WT: if (mdone) state_q <= ST_PCHK;
				ST_PCHK: state_q <= (count_q >= CW'(2)) ? ST_PRD1 : ST_PUSH;
				ST_PRD1: state_q <= ST_PRD2;
				ST_PRD2: state_q <= ST_PM1_GO;
				ST_PM1_GO: state_q <= ST_PM1_WT;
				ST_PM1_WT: if (mdone) state_q <= ST_PM2_GO;
				ST_PM2_GO: state_q <= ST_PM2_WT;
				ST_PM2_WT: if (mdone) begin
					if (redundant) begin
						count_q <= count_q - CW'(1);
						state_q <= ST_PCHK;
					end else state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					// full hull: new line is dropped
					if (count_q < CW'(MAX_LINES)) count_q <= count_q + CW'(1);
					state_q <= ST_QCLAMP;
				end
				ST_QCLAMP: begin
					qp_q <= qp_c;
					state_q <= ST_QV_LD;
				end
				ST_QV_LD: state_q <= ST_QV_GO;
				ST_QV_GO: state_q <= ST_QV_WT;
				ST_QV_WT: if (mdone) state_q <= ST_QLAST;
				ST_QLAST: state_q <= (qp_q + CW'(1) < count_q) ? ST_QN_LD : ST_S_GO;
				ST_QN_LD: state_q <= ST_QN_GO;
				ST_QN_GO: state_q <= ST_QN_WT;
				ST_QN_WT: if (mdone) begin
					if (adv) begin
						qp_q <= qp_q + CW'(1);
						state_q <= ST_QLAST;
					end else state_q <= ST_S_GO;
				end
				ST_S_GO: state_q <= ST_S_WT;
				ST_S_WT: if (mdone) state_q <= ST_S2_GO;
				ST_S2_GO: state_q <= ST_S2_WT;
				ST_S2_WT: if (mdone) state_q <= ST_OUT;
				ST_OUT: if (out_free) begin
					state_q <= ST_IDLE;
					if (last_q) begin
						// sequence end: back to the reset state, registers stay
						psum_q <= '0;
						prev_best_q <= '0;
						count_q <= '0;
						qp_q <= '0;
					end else begin
						psum_q <= s_q;
						prev_best_q <= best_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath; products are taken in the cycle that done is high
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_acc) begin
				// prefix sum wraps at its width
				s_q <= psum_q + PREFIX_W'(in_ch.item_value);
				last_q <= in_ch.seq_last;
			end
			ST_A_WT: if (mdone) begin
				m3_q <= {{(64-SLOPE_W){slope64[SLOPE_W-1]}}, slope64[SLOPE_W-1:0]};
				tmp_q <= mprod[63:0] - lin64;
			end
			// intercept = P*(quad*P - lin) + prev_best
			ST_B_WT: if (mdone) icpt_q <= mprod[63:0] + prev_best_q;
			ST_PRD1: begin
				m1_q <= rd_slope64;
				b1_q <= rd_icpt_q;
			end
			ST_PRD2: begin
				m2_q <= rd_slope64;
				b2_q <= rd_icpt_q;
			end
			ST_PM1_WT: if (mdone) begin
				lp_q <= mprod;
				ln_q <= (mprod != '0) && (bn1 != sn1);
			end
			ST_QV_LD: begin
				m1_q <= rd_slope64;
				b1_q <= rd_icpt_q;
			end
			ST_QV_WT: if (mdone) va_q <= mprod[63:0] + b1_q;
			ST_QN_LD: begin
				m2_q <= rd_slope64;
				b2_q <= rd_icpt_q;
			end
			ST_QN_WT: if (mdone && adv) va_q <= tn;
			// score = line value + const + S*(quad*S + lin)
			ST_S_WT: if (mdone) tmp_q <= mprod[63:0] + lin64;
			ST_S2_WT: if (mdone) best_q <= mprod[63:0] + va_q + const64;
			ST_OUT: if (out_free) begin
				out_ch.best_score <= best_q;
				out_ch.score_last <= last_q;
			end
			default: ;
		endcase
	end

	`SPH_ASSERT(a_out_valid_hold, clk, arst_n, (out_ch.valid && !out_ch.ready) |=> out_ch.valid, "result dropped")
	`SPH_ASSERT(a_out_data_hold, clk, arst_n, (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.best_score), "score changed")
	`SPH_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(MAX_LINES), "hull count past depth")
	`SPH_ASSERT(a_ptr_bound, clk, arst_n, (state_q == ST_S_GO) |-> (qp_q < count_q), "pointer past hull")
endmodule
`default_nettype wire

// ----- bench/tb_segment_partition_dp_hull.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_segment_partition_dp_hull;
	import sph_pkg::*;

	localparam int HULL_DEPTH = 1024;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	sph_in_if in_ch ();
	sph_out_if out_ch ();

	segment_partition_dp_hull #(.MAX_LINES(HULL_DEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// items waiting to be driven, and scores still owed by the block
	in_item_t pending_items[$];
	out_item_t owed_scores[$];
	int errors = 0;
	int idle_pct = 28;       // idle chance per cycle, both sides
	bit hold_input = 0;      // sender pause until the block drains

	// predictor copy of the registers (sign-extended to 64 bits)
	logic [63:0] quad_q, lin_q, const_q;

	// predictor copy of the per-sequence state
	logic [PREFIX_W-1:0] run_sum;
	logic [63:0] last_best;
	logic signed [SLOPE_W-1:0] line_m[HULL_DEPTH];
	logic [63:0] line_b[HULL_DEPTH];
	int line_cnt;
	int scan_pos;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] eval_line(int i, logic [63:0] x);
		logic [63:0] m64;
		m64 = {{(64-SLOPE_W){line_m[i][SLOPE_W-1]}}, line_m[i]};
		return m64 * x + line_b[i];
	endfunction

	// middle line j is dropped when the new line and line i cross no later
	// than lines i and j; exact 128-bit products, no wrap
	function automatic bit middle_dead(int i, int j, logic signed [SLOPE_W-1:0] m3,
			logic [63:0] b3);
		logic signed [127:0] b1, b2, bn, m1, m2, mn, lhs, rhs;
		b1 = signed'(line_b[i]);
		b2 = signed'(line_b[j]);
		bn = signed'(b3);
		m1 = line_m[i];
		m2 = line_m[j];
		mn = m3;
		lhs = (bn - b1) * (m1 - m2);
		rhs = (b2 - b1) * (m1 - mn);
		return lhs <= rhs;
	endfunction

	function automatic void clear_run();
		run_sum = '0;
		last_best = '0;
		line_cnt = 0;
		scan_pos = 0;
	endfunction

	// best partition score for the prefix that this item closes
	function automatic out_item_t best_split(in_item_t it);
		logic [63:0] p, s, slope64, icpt, v;
		logic signed [SLOPE_W-1:0] m3;
		out_item_t r;
		p = {{(64-PREFIX_W){1'b0}}, run_sum};
		slope64 = 64'd0 - 64'd2 * quad_q * p;
		m3 = slope64[SLOPE_W-1:0];
		icpt = quad_q * p * p - lin_q * p + last_best;
		while (line_cnt >= 2 && middle_dead(line_cnt - 2, line_cnt - 1, m3, icpt))
			line_cnt--;
		if (line_cnt < HULL_DEPTH) begin
			line_m[line_cnt] = m3;
			line_b[line_cnt] = icpt;
			line_cnt++;
		end
		run_sum = run_sum + PREFIX_W'(it.item_value);
		s = {{(64-PREFIX_W){1'b0}}, run_sum};
		if (scan_pos >= line_cnt)
			scan_pos = line_cnt - 1;
		while (scan_pos + 1 < line_cnt &&
				signed'(eval_line(scan_pos, s)) < signed'(eval_line(scan_pos + 1, s)))
			scan_pos++;
		v = eval_line(scan_pos, s) + const_q + quad_q * s * s + lin_q * s;
		last_best = v;
		r.best_score = v;
		r.score_last = it.seq_last;
		if (it.seq_last)
			clear_run();
		return r;
	endfunction

	// sender: holds an offered item until taken, then idles at random
	always @(posedge clk or negedge arst_n) begin
		in_item_t nxt;
		bit offer;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.item_value <= '0;
			in_ch.seq_last <= 1'b0;
		end else if (!(in_ch.valid && !in_ch.ready)) begin
			if (in_ch.valid && in_ch.ready) begin
				owed_scores = {owed_scores, best_split(pending_items[0])};
				void'(pending_items.pop_front());
			end
			offer = pending_items.size() > 0 && !hold_input &&
				$urandom_range(0, 99) >= idle_pct;
			in_ch.valid <= offer;
			if (offer) begin
				nxt = pending_items[0];
				in_ch.item_value <= nxt.item_value;
				in_ch.seq_last <= nxt.seq_last;
			end
		end
	end

	// receiver: random backpressure, checks each score against the oldest owed
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_s;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (owed_scores.size() == 0) begin
					$error("unexpected score %0d", out_ch.best_score);
					errors++;
				end else begin
					exp_s = owed_scores.pop_front();
					if (out_ch.best_score !== exp_s.best_score) begin
						$error("best_score expected %0d actual %0d",
							signed'(exp_s.best_score), out_ch.best_score);
						errors++;
					end
					if (out_ch.score_last !== exp_s.score_last) begin
						$error("score_last expected %0b actual %0b",
							exp_s.score_last, out_ch.score_last);
						errors++;
					end
				end
			end
			out_ch.ready <= $urandom_range(0, 99) >= idle_pct;
		end
	end

	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_QUAD:  quad_q = {{53{val[10]}}, val[10:0]};
			REG_LIN:   lin_q = {{40{val[23]}}, val[23:0]};
			REG_CONST: const_q = {{32{val[31]}}, val};
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_item(int val, bit last);
		in_item_t it;
		it.item_value = val[7:0];
		it.seq_last = last;
		pending_items = {pending_items, it};
	endtask

	// random sequence; a few long ones so the hull and pointer get deep
	task automatic add_sequence();
		int len;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 25);
		for (int k = 0; k < len; k++)
			add_item($urandom_range(0, 255), k == len - 1);
	endtask

	task automatic drain();
		wait (pending_items.size() == 0 && owed_scores.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		int budget;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quad_q = '1;
		lin_q = '0;
		const_q = '0;
		clear_run();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed, reset coefficients: single-item sequences, extremes,
		// zero runs, a value of 255 after a zero
		add_item(0, 1);
		add_item(255, 1);
		add_item(0, 0); add_item(0, 0); add_item(255, 0); add_item(255, 1);
		add_item(1, 0); add_item(128, 0); add_item(127, 0); add_item(255, 0);
		add_item(85, 0); add_item(170, 1);
		drain();

		// extremes of every coefficient
		reg_write(REG_QUAD, CFG_W'(-1023));
		reg_write(REG_LIN, CFG_W'(-8388608));
		reg_write(REG_CONST, 32'h8000_0000);
		add_item(255, 0); add_item(255, 0); add_item(0, 0); add_item(255, 1);
		for (int k = 0; k < 8; k++)
			add_sequence();
		drain();

		reg_write(REG_QUAD, CFG_W'(-1));
		reg_write(REG_LIN, CFG_W'(8388607));
		reg_write(REG_CONST, 32'h7fff_ffff);
		add_item(255, 0); add_item(0, 0); add_item(7, 1);
		// long stretch without idling on either side
		idle_pct = 0;
		for (int k = 0; k < 5; k++)
			add_sequence();
		drain();
		idle_pct = 28;

		// one long sequence of mostly full values; deep hull, wide intercepts
		reg_write(REG_QUAD, CFG_W'(-3));
		reg_write(REG_LIN, CFG_W'(12345));
		reg_write(REG_CONST, CFG_W'(-2));
		for (int k = 0; k < 200; k++)
			add_item(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : 255, k == 199);
		drain();

		// random coefficients, some outside the documented range
		for (int ph = 0; ph < 4; ph++) begin
			reg_write(REG_QUAD, (ph == 3) ? CFG_W'($urandom_range(0, 1023))
				: CFG_W'(-$urandom_range(1, 1023)));
			reg_write(REG_LIN, $urandom);
			reg_write(REG_CONST, $urandom);
			budget = 0;
			while (budget < 3) begin
				add_sequence();
				budget++;
				// sender pause until everything owed has arrived
				if (budget == 2) begin
					hold_input = 1;
					wait (owed_scores.size() == 0);
					hold_input = 0;
				end
			end
			drain();
		end

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("segment_partition_dp_hull verification clean");
		else
			$display("segment_partition_dp_hull verification failed");
		$finish;
	end

	initial begin
		#50ms;
		$display("segment_partition_dp_hull verification failed");
		$finish;
	end
endmodule
`default_nettype wire
